@@ src/cfb_pkg.sv @@
`timescale 1ns / 1ps

package cfb_pkg;

  localparam int unsigned MemDepth  = 512;
  localparam int unsigned AddrW     = 9;
  localparam int unsigned LenW      = 10;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [31:0]     CrcPoly   = 32'hEDB88320;
  localparam logic [31:0]     CrcOnes   = 32'hFFFFFFFF;
  localparam logic [7:0]      CodeFull  = 8'hFF;
  localparam logic [LenW-1:0] CountSat  = LenW'(MemDepth);
  localparam logic [LenW-1:0] BufReset  = LenW'(512);
  localparam logic [2:0]      LastCrcIdx = 3'd4;

  // register index within the configuration space
  localparam logic REG_OUT_CAP = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } cfb_in_t;

  typedef struct packed {
    logic             write_valid;
    logic [AddrW-1:0] write_addr;
    logic [7:0]       write_byte;
    logic             frame_done;
    logic [LenW-1:0]  frame_len;
    logic             frame_error;
    logic             run_last;
  } cfb_out_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        too_small;
    logic [31:0] crc_final;
  } cfb_entry_t;

  typedef enum logic [2:0] {
    ST_BYTE,
    ST_FULL,
    ST_CODE,
    ST_TERM,
    ST_ERR
  } cfb_state_e;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [LenW-1:0] eff_limit(logic [LenW-1:0] buf_size);
    return (buf_size < LenW'(MemDepth)) ? buf_size : LenW'(MemDepth);
  endfunction

endpackage

@@ src/cfb_front.sv @@
`timescale 1ns / 1ps

module cfb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cfb_pkg::LenW-1:0]  limit_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  cfb_pkg::cfb_in_t          in_item_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output cfb_pkg::cfb_entry_t       push_entry_o
);

  logic [31:0]              crc_q, crc_d;
  logic [cfb_pkg::LenW-1:0] count_q, count_d;
  logic [31:0]              crc_next;
  logic [cfb_pkg::LenW-1:0] count_next;
  logic [cfb_pkg::LenW:0]   need;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign crc_next   = cfb_pkg::crc32_byte(crc_q, in_item_i.data_byte);
  assign count_next = (count_q < cfb_pkg::CountSat) ? count_q + 1'b1 : cfb_pkg::CountSat;
  // payload plus four crc bytes, a code byte and the terminator
  assign need       = {1'b0, count_next} + (cfb_pkg::LenW + 1)'(6);

  always_comb begin
    push_entry_o.data_byte = in_item_i.data_byte;
    push_entry_o.frame_end = in_item_i.frame_end;
    push_entry_o.too_small = need > {1'b0, limit_i};
    push_entry_o.crc_final = crc_next ^ cfb_pkg::CrcOnes;
  end

  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    if (push_o) begin
      if (in_item_i.frame_end) begin
        crc_d   = cfb_pkg::CrcOnes;
        count_d = '0;
      end else begin
        crc_d   = crc_next;
        count_d = count_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= cfb_pkg::CrcOnes;
      count_q <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
    end
  end

endmodule

@@ src/cfb_queue.sv @@
`timescale 1ns / 1ps

module cfb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfb_pkg::cfb_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output cfb_pkg::cfb_entry_t head_o
);

  cfb_pkg::cfb_entry_t              entry_q [cfb_pkg::QueueDepth];
  logic [cfb_pkg::QueuePtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [cfb_pkg::QueuePtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [cfb_pkg::QueuePtrW:0]      fill_q, fill_d;

  assign full_o       = fill_q == (cfb_pkg::QueuePtrW + 1)'(cfb_pkg::QueueDepth);
  assign head_valid_o = fill_q != '0;
  assign head_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ src/cfb_back.sv @@
`timescale 1ns / 1ps

module cfb_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cfb_pkg::LenW-1:0]  limit_i,
  input  logic                      head_valid_i,
  input  cfb_pkg::cfb_entry_t       head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output cfb_pkg::cfb_out_t         out_item_o
);

  cfb_pkg::cfb_state_e       state_q, state_d;
  logic [2:0]                idx_q, idx_d;
  logic [cfb_pkg::LenW-1:0]  write_pos_q, write_pos_d;
  logic [cfb_pkg::AddrW-1:0] code_pos_q, code_pos_d;
  logic [7:0]                run_code_q, run_code_d;
  logic                      failed_q, failed_d;
  logic                      out_valid_q, out_valid_d;
  cfb_pkg::cfb_out_t         out_q, out_d;

  logic                      slot_free;
  logic                      emit;
  cfb_pkg::cfb_out_t         res;
  logic [7:0]                cur_byte;
  logic [cfb_pkg::LenW-1:0]  wp_inc;
  logic [7:0]                rc_inc;
  logic                      byte_done;
  logic                      frame_clear;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign wp_inc    = write_pos_q + 1'b1;
  assign rc_inc    = run_code_q + 1'b1;

  always_comb begin
    case (idx_q)
      3'd1:    cur_byte = head_i.crc_final[7:0];
      3'd2:    cur_byte = head_i.crc_final[15:8];
      3'd3:    cur_byte = head_i.crc_final[23:16];
      3'd4:    cur_byte = head_i.crc_final[31:24];
      default: cur_byte = head_i.data_byte;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    write_pos_d = write_pos_q;
    code_pos_d  = code_pos_q;
    run_code_d  = run_code_q;
    failed_d    = failed_q;
    pop_o       = 1'b0;
    emit        = 1'b0;
    res         = '0;
    byte_done   = 1'b0;
    frame_clear = 1'b0;

    case (state_q)
      cfb_pkg::ST_BYTE: begin
        if (head_valid_i && failed_q && !head_i.frame_end) begin
          // rest of a failed frame is swallowed
          pop_o = 1'b1;
        end else if (head_valid_i && slot_free) begin
          emit = 1'b1;
          if (failed_q || (idx_q == '0 && head_i.frame_end && head_i.too_small)) begin
            res.frame_done  = 1'b1;
            res.frame_error = 1'b1;
            res.run_last    = 1'b1;
            pop_o           = 1'b1;
            frame_clear     = 1'b1;
          end else if (cur_byte == '0) begin
            res.write_valid = 1'b1;
            res.write_addr  = code_pos_q;
            res.write_byte  = run_code_q;
            code_pos_d      = write_pos_q[cfb_pkg::AddrW-1:0];
            run_code_d      = 8'd1;
            write_pos_d     = wp_inc;
            byte_done       = 1'b1;
          end else begin
            res.write_valid = 1'b1;
            res.write_addr  = write_pos_q[cfb_pkg::AddrW-1:0];
            res.write_byte  = cur_byte;
            write_pos_d     = wp_inc;
            run_code_d      = rc_inc;
            if (rc_inc == cfb_pkg::CodeFull) begin
              state_d = cfb_pkg::ST_FULL;
            end else begin
              byte_done = 1'b1;
            end
          end
        end
      end
      cfb_pkg::ST_FULL: begin
        if (slot_free) begin
          emit            = 1'b1;
          res.write_valid = 1'b1;
          res.write_addr  = code_pos_q;
          res.write_byte  = cfb_pkg::CodeFull;
          code_pos_d      = write_pos_q[cfb_pkg::AddrW-1:0];
          run_code_d      = 8'd1;
          write_pos_d     = wp_inc;
          byte_done       = 1'b1;
        end
      end
      cfb_pkg::ST_CODE: begin
        if (slot_free) begin
          emit            = 1'b1;
          res.write_valid = 1'b1;
          res.write_addr  = code_pos_q;
          res.write_byte  = run_code_q;
          state_d         = cfb_pkg::ST_TERM;
        end
      end
      cfb_pkg::ST_TERM: begin
        if (slot_free) begin
          emit            = 1'b1;
          res.write_valid = 1'b1;
          res.write_addr  = write_pos_q[cfb_pkg::AddrW-1:0];
          res.frame_done  = 1'b1;
          res.frame_len   = wp_inc;
          res.run_last    = 1'b1;
          pop_o           = 1'b1;
          frame_clear     = 1'b1;
        end
      end
      cfb_pkg::ST_ERR: begin
        if (slot_free) begin
          emit            = 1'b1;
          res.frame_done  = 1'b1;
          res.frame_error = 1'b1;
          res.run_last    = 1'b1;
          pop_o           = 1'b1;
          frame_clear     = 1'b1;
        end
      end
      default: begin
        state_d = cfb_pkg::ST_BYTE;
      end
    endcase

    // end of one encoded byte: overflow check and next step
    if (byte_done) begin
      state_d = cfb_pkg::ST_BYTE;
      if (write_pos_d >= limit_i) begin
        failed_d = 1'b1;
        idx_d    = '0;
        if (head_i.frame_end) begin
          state_d = cfb_pkg::ST_ERR;
        end else begin
          res.run_last = 1'b1;
          pop_o        = 1'b1;
        end
      end else if (!head_i.frame_end) begin
        res.run_last = 1'b1;
        pop_o        = 1'b1;
      end else if (idx_q == cfb_pkg::LastCrcIdx) begin
        state_d = cfb_pkg::ST_CODE;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (frame_clear) begin
      state_d     = cfb_pkg::ST_BYTE;
      idx_d       = '0;
      write_pos_d = cfb_pkg::LenW'(1);
      code_pos_d  = '0;
      run_code_d  = 8'd1;
      failed_d    = 1'b0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfb_pkg::ST_BYTE;
      idx_q       <= '0;
      write_pos_q <= cfb_pkg::LenW'(1);
      code_pos_q  <= '0;
      run_code_q  <= 8'd1;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      write_pos_q <= write_pos_d;
      code_pos_q  <= code_pos_d;
      run_code_q  <= run_code_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_write_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_pos_q != '0)
    else $error("write position fell to zero");

  a_run_code_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_code_q != '0)
    else $error("run code fell to zero");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |-> out_item_o.run_last)
    else $error("frame done result not marked as last");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("queue popped while empty");

endmodule

@@ src/cobs_crc32_frame_builder.sv @@
// taken requests pass through the request queue; results leave from the output register
// throughput: one payload request per clock while the request queue has room;
// a byte closing a full block adds a code write; a frame end request adds crc bytes,
// at most one full-block code, run code and terminator, absorbed by the four-entry queue
// reset (rst_ni, async, active low): crc, counters and encoder state return to frame start,
// the output capacity register returns to 512
`timescale 1ns / 1ps

module cobs_crc32_frame_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  // payload request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfb_pkg::cfb_in_t    in_item_i,
  // memory write / status result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cfb_pkg::cfb_out_t   out_item_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [cfb_pkg::LenW-1:0] buf_size_q, buf_size_d;
  logic [cfb_pkg::LenW-1:0] limit;
  logic                     reg_hit;

  logic                     q_full;
  logic                     push;
  cfb_pkg::cfb_entry_t      push_entry;
  logic                     pop;
  logic                     head_valid;
  cfb_pkg::cfb_entry_t      head;

  // single register, word aligned; upper address bit selects beyond the list
  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == cfb_pkg::REG_OUT_CAP;
  assign prdata  = reg_hit ? {22'h0, buf_size_q} : 32'h0;

  always_comb begin
    buf_size_d = buf_size_q;
    if (psel && penable && pwrite && pready && reg_hit) begin
      buf_size_d = pwdata[cfb_pkg::LenW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= cfb_pkg::BufReset;
    end else begin
      buf_size_q <= buf_size_d;
    end
  end

  // usable output memory, capped at the physical depth
  assign limit = cfb_pkg::eff_limit(buf_size_q);

  // front: running crc, payload count and the too-small check at frame end
  cfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // short queue decoupling the byte stream from the end of frame burst
  cfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: cobs sequencer, one memory write or status result per clock unless output stalls
  cfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_i      (limit),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ test/cobs_crc32_frame_builder_tb.sv @@
`timescale 1ns / 1ps

module cobs_crc32_frame_builder_tb;

  localparam int unsigned HalfPeriod  = 5;
  // results can trail their request by the queue depth plus a frame-end burst
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned TimeoutNs   = 5_000_000;
  localparam int unsigned PhaseItems  = 38;

  localparam logic [31:0] CrcReflPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcAllOnes    = 32'hFFFFFFFF;
  localparam logic [7:0]  BlockFullCode = 8'hFF;
  localparam logic [9:0]  MemBytes      = 10'd512;
  localparam logic [9:0]  PayloadCap    = 10'd512;
  localparam logic [2:0]  BufSizeAddr   = 3'(4 * cfb_pkg::REG_OUT_CAP);

  // every input known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  cfb_pkg::cfb_in_t  in_item_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  cfb_pkg::cfb_out_t out_item_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [2:0]        paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the encoder: configuration and per-frame state
  logic [9:0]  buf_size = 10'd512;
  logic [31:0] crc_acc;
  logic [9:0]  wr_pos;
  logic [8:0]  code_at;
  logic [7:0]  run_len;
  logic [9:0]  pay_cnt;
  bit          frame_failed;

  cfb_pkg::cfb_in_t  pending_bytes[$];   // requests still to be offered
  cfb_pkg::cfb_out_t step_writes[$];     // writes caused by the request being predicted
  cfb_pkg::cfb_out_t expected_writes[$]; // writes and status still owed by the block

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned err_cnt       = 0;
  int unsigned queued_count  = 0;
  bit          req_held      = 1'b0;

  cobs_crc32_frame_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // frame encoder prediction
  // ---------------------------------------------------------------------------

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("%s", msg);
  endfunction

  // memory depth caps whatever the register says
  function automatic logic [9:0] usable_limit();
    return (buf_size < MemBytes) ? buf_size : MemBytes;
  endfunction

  function automatic void restart_frame();
    crc_acc      = CrcAllOnes;
    wr_pos       = 10'd1;
    code_at      = 9'd0;
    run_len      = 8'd1;
    pay_cnt      = 10'd0;
    frame_failed = 1'b0;
  endfunction

  function automatic void add_result(logic wv, logic [8:0] addr, logic [7:0] data,
                                     logic done, logic [9:0] len, logic err);
    cfb_pkg::cfb_out_t r;
    r.write_valid = wv;
    r.write_addr  = addr;
    r.write_byte  = data;
    r.frame_done  = done;
    r.frame_len   = len;
    r.frame_error = err;
    r.run_last    = 1'b0;
    step_writes.push_back(r);
  endfunction

  // reflected crc-32, one byte lsb first
  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] v;
    int          k;
    v = c ^ {24'h0, b};
    for (k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CrcReflPoly) : (v >> 1);
    end
    return v;
  endfunction

  // cobs step for one byte; a zero or a full block closes the run by writing
  // its code back at the reserved slot; returns 1 when the buffer is exhausted
  function automatic bit encode_byte(logic [7:0] b);
    if (b == 8'h00) begin
      add_result(1'b1, code_at, run_len, 1'b0, '0, 1'b0);
      code_at = wr_pos[8:0];
      run_len = 8'd1;
      wr_pos  = wr_pos + 10'd1;
    end else begin
      add_result(1'b1, wr_pos[8:0], b, 1'b0, '0, 1'b0);
      wr_pos  = wr_pos + 10'd1;
      run_len = run_len + 8'd1;
      if (run_len == BlockFullCode) begin
        add_result(1'b1, code_at, run_len, 1'b0, '0, 1'b0);
        code_at = wr_pos[8:0];
        run_len = 8'd1;
        wr_pos  = wr_pos + 10'd1;
      end
    end
    return wr_pos >= usable_limit();
  endfunction

  function automatic void predict_request(cfb_pkg::cfb_in_t req);
    logic [9:0]        cnt;
    logic [31:0]       crc_out;
    cfb_pkg::cfb_out_t r;
    int                k;
    step_writes.delete();
    // payload plus crc, code and terminator must fit before the last byte is encoded
    if (!frame_failed && req.frame_end) begin
      cnt = (pay_cnt < PayloadCap) ? pay_cnt + 10'd1 : PayloadCap;
      if ({1'b0, cnt} + 11'd6 > {1'b0, usable_limit()}) frame_failed = 1'b1;
    end
    if (!frame_failed) begin
      crc_acc = crc_update(crc_acc, req.data_byte);
      if (pay_cnt < PayloadCap) pay_cnt = pay_cnt + 10'd1;
      if (encode_byte(req.data_byte)) frame_failed = 1'b1;
    end
    // crc trailer, least significant byte first
    if (req.frame_end && !frame_failed) begin
      crc_out = crc_acc ^ CrcAllOnes;
      for (k = 0; k < 4 && !frame_failed; k++) begin
        if (encode_byte(crc_out[8*k +: 8])) frame_failed = 1'b1;
      end
    end
    if (req.frame_end) begin
      if (!frame_failed) begin
        add_result(1'b1, code_at, run_len, 1'b0, '0, 1'b0);
        add_result(1'b1, wr_pos[8:0], 8'h00, 1'b1, wr_pos + 10'd1, 1'b0);
      end else begin
        add_result(1'b0, '0, '0, 1'b1, '0, 1'b1);
      end
      restart_frame();
    end
    // a swallowed byte leaves nothing to mark
    if (step_writes.size() != 0) begin
      r = step_writes.pop_back();
      r.run_last = 1'b1;
      step_writes.push_back(r);
    end
    foreach (step_writes[i]) expected_writes.push_back(step_writes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: requests and receiver stall change on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // a stalled request stays put; otherwise offer the next one or idle
      if (!req_held) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_bytes[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cfb_pkg::cfb_out_t want;
    if (rst_ni) begin
      // results first, so a request taken on this edge cannot feed this check
      if (out_valid_o && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          note_error($sformatf({"unexpected result: valid=%0d addr=%0d byte=%02h",
                                " done=%0d len=%0d err=%0d last=%0d"},
                               out_item_o.write_valid, out_item_o.write_addr,
                               out_item_o.write_byte, out_item_o.frame_done,
                               out_item_o.frame_len, out_item_o.frame_error,
                               out_item_o.run_last));
        end else begin
          want = expected_writes.pop_front();
          if (out_item_o.write_valid !== want.write_valid ||
              out_item_o.write_addr  !== want.write_addr  ||
              out_item_o.write_byte  !== want.write_byte  ||
              out_item_o.frame_done  !== want.frame_done  ||
              out_item_o.frame_len   !== want.frame_len   ||
              out_item_o.frame_error !== want.frame_error ||
              out_item_o.run_last    !== want.run_last) begin
            note_error($sformatf({"mismatch at %0t: exp valid=%0d addr=%0d byte=%02h done=%0d",
                                  " len=%0d err=%0d last=%0d | got valid=%0d addr=%0d byte=%02h",
                                  " done=%0d len=%0d err=%0d last=%0d"}, $realtime,
                                 want.write_valid, want.write_addr, want.write_byte,
                                 want.frame_done, want.frame_len, want.frame_error,
                                 want.run_last, out_item_o.write_valid,
                                 out_item_o.write_addr, out_item_o.write_byte,
                                 out_item_o.frame_done, out_item_o.frame_len,
                                 out_item_o.frame_error, out_item_o.run_last));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_request(in_item_i);
        void'(pending_bytes.pop_front());
      end
      req_held = in_valid_i && in_stall_o;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_request(input logic [7:0] b, input logic last);
    cfb_pkg::cfb_in_t req;
    req.data_byte = b;
    req.frame_end = last;
    pending_bytes.push_back(req);
    queued_count++;
  endtask

  // short frames mostly, now and then a longer one, capped by what is left of
  // the budget; zeros are frequent so runs close often
  task automatic push_random_frame(input int unsigned max_len);
    int unsigned len;
    int unsigned i;
    logic [7:0]  b;
    len = ($urandom_range(7) == 0) ? $urandom_range(70, 21) : $urandom_range(20, 1);
    if (len > max_len) len = max_len;
    for (i = 1; i <= len; i++) begin
      case ($urandom_range(9))
        0, 1, 2: b = 8'h00;
        3:       b = 8'hFF;
        4:       b = 8'h01;
        default: b = 8'($urandom);
      endcase
      push_request(b, i == len);
    end
  endtask

  // sender pauses until nothing is owed, then keeps the clock running for swallowed bytes
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_writes.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write then read back the output capacity register
  task automatic set_out_cap(input logic [9:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BufSizeAddr;
    pwdata  <= {22'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    buf_size = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata !== {22'h0, value}) begin
      note_error($sformatf("output capacity read back %0h, wrote %0h", prdata, value));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one idle and stall mix and one buffer size, with a full drain halfway through
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input logic [9:0] size_val);
    int unsigned base;
    set_out_cap(size_val);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (2) begin
      base = queued_count;
      while (queued_count - base < PhaseItems / 2) begin
        push_random_frame(PhaseItems / 2 - (queued_count - base));
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    restart_frame();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset buffer size: a lone zero, then extremes of the byte range
    push_request(8'h00, 1'b1);
    push_request(8'hFF, 1'b0);
    push_request(8'h00, 1'b0);
    push_request(8'h80, 1'b0);
    push_request(8'h01, 1'b1);
    push_request(8'h55, 1'b1);
    wait_idle();

    // seven bytes: a one-byte frame fits exactly, a two-byte frame is too big
    set_out_cap(10'd7);
    push_request(8'hAA, 1'b1);
    push_request(8'h00, 1'b0);
    push_request(8'h11, 1'b1);
    wait_idle();

    // six bytes never hold a frame
    set_out_cap(10'd6);
    push_request(8'h12, 1'b1);
    wait_idle();

    // tiny buffer: overflow on the second byte, the frame end then reports an error
    set_out_cap(10'd3);
    push_request(8'h01, 1'b0);
    push_request(8'h02, 1'b0);
    push_request(8'h03, 1'b1);
    wait_idle();

    // zero buffer: the lone frame fails the too-small check before any write
    set_out_cap(10'd0);
    push_request(8'h7F, 1'b1);
    wait_idle();

    // buffer shrunk in the middle of a frame takes effect straight away
    set_out_cap(10'd512);
    push_request(8'h10, 1'b0);
    push_request(8'h20, 1'b0);
    wait_idle();
    set_out_cap(10'd8);
    push_request(8'h30, 1'b1);
    wait_idle();

    // random frames, no idling, register above the memory depth
    run_phase(0, 0, 10'd1023);

    // small buffer so the longer random frames hit the too-small check
    run_phase(78, 0, 10'd20);
    run_phase(0, 78, 10'd512);
    run_phase(28, 28, 10'd100);

    if (err_cnt == 0) begin
      $display("cobs_crc32_frame_builder_tb: done, clean");
    end else begin
      $display("cobs_crc32_frame_builder_tb: done, errors");
    end
    $finish;
  end

  // watchdog against a hung handshake or a result that never comes
  initial begin
    #(TimeoutNs);
    $display("cobs_crc32_frame_builder_tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
src/cfb_pkg.sv
src/cfb_front.sv
src/cfb_queue.sv
src/cfb_back.sv
src/cobs_crc32_frame_builder.sv
test/cobs_crc32_frame_builder_tb.sv
